// ===== design/deq_pkg.sv =====
// Shared types and constants of the double-ended queue.
package deq_pkg;

  // Default sizing of the queue
  localparam int unsigned DefDepth     = 16;
  localparam int unsigned DefDataWidth = 32;

  // Fixed widths of the item fields
  localparam int unsigned ActionW = 2;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned OccW    = 5;
  localparam int unsigned StatusW = 2;

  // Action codes carried by an input item
  typedef enum logic [ActionW-1:0] {
    ActPushFront = 2'd0,
    ActPushBack  = 2'd1,
    ActPopFront  = 2'd2,
    ActPopBack   = 2'd3
  } deq_action_e;

  // Status codes carried by a result item
  typedef enum logic [StatusW-1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } deq_status_e;

  // Result fields known at accept time, handed from control to the output stage
  typedef struct packed {
    logic              pop;       // successful pop, data comes from the store
    logic [OccW-1:0]   occ;
    logic              is_empty;
    deq_status_e       status;
  } deq_meta_t;

endpackage

// ===== design/deq_in_if.sv =====
// Input channel of the double-ended queue: action items.
interface deq_in_if;
  logic                          valid;
  logic                          ready;
  logic [deq_pkg::ActionW-1:0]   action;
  logic [deq_pkg::ValueW-1:0]    push_value;

  modport source (output valid, output action, output push_value, input ready);
  modport sink   (input valid, input action, input push_value, output ready);
endinterface

// ===== design/deq_out_if.sv =====
// Output channel of the double-ended queue: result items.
interface deq_out_if;
  logic                          valid;
  logic                          ready;
  logic [deq_pkg::ValueW-1:0]    popped_value;
  logic [deq_pkg::OccW-1:0]      occupancy;
  logic                          is_empty;
  logic [deq_pkg::StatusW-1:0]   status;

  modport source (output valid, output popped_value, output occupancy, output is_empty,
                  output status, input ready);
  modport sink   (input valid, input popped_value, input occupancy, input is_empty,
                  input status, output ready);
endinterface

// ===== design/deq_mem.sv =====
// Single-port element store with registered read data.
module deq_mem #(
  parameter int unsigned DEPTH      = deq_pkg::DefDepth,
  parameter int unsigned DATA_WIDTH = deq_pkg::DefDataWidth,
  localparam int unsigned PtrW      = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic                  we_i,
  input  logic [PtrW-1:0]       addr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  // Write or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/deq_ctrl.sv =====
// Pointer and count control: decodes each action and drives the store port.
module deq_ctrl #(
  parameter int unsigned DEPTH      = deq_pkg::DefDepth,
  parameter int unsigned DATA_WIDTH = deq_pkg::DefDataWidth,
  localparam int unsigned PtrW      = $clog2(DEPTH),
  localparam int unsigned CntW      = $clog2(DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [deq_pkg::ActionW-1:0]   action_i,
  input  logic [deq_pkg::ValueW-1:0]    push_value_i,
  output logic                          mem_en_o,
  output logic                          mem_we_o,
  output logic [PtrW-1:0]               mem_addr_o,
  output logic [DATA_WIDTH-1:0]         mem_wdata_o,
  output deq_pkg::deq_meta_t            meta_o
);

  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [PtrW-1:0] front_q, front_d;
  logic [PtrW-1:0] back_q, back_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            full, empty;
  logic [63:0]     value_wide;
  logic [CntW+deq_pkg::OccW-1:0] cnt_wide;
  deq_pkg::deq_action_e action;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrLast) ? '0 : p + PtrW'(1);
  endfunction

  function automatic logic [PtrW-1:0] ptr_dec(input logic [PtrW-1:0] p);
    ptr_dec = (p == '0) ? PtrLast : p - PtrW'(1);
  endfunction

  assign action      = deq_pkg::deq_action_e'(action_i);
  assign full        = (cnt_q == CntFull);
  assign empty       = (cnt_q == '0);
  assign value_wide  = 64'(push_value_i);
  assign mem_wdata_o = value_wide[DATA_WIDTH-1:0];

  // Action decode: next pointers, count and store access
  always_comb begin
    front_d        = front_q;
    back_d         = back_q;
    cnt_d          = cnt_q;
    mem_en_o       = 1'b0;
    mem_we_o       = 1'b0;
    mem_addr_o     = front_q;
    meta_o.pop     = 1'b0;
    meta_o.status  = deq_pkg::StOk;
    case (action)
      deq_pkg::ActPushFront: begin
        if (full) begin
          meta_o.status = deq_pkg::StFull;
        end else begin
          front_d    = ptr_dec(front_q);
          mem_en_o   = 1'b1;
          mem_we_o   = 1'b1;
          mem_addr_o = front_d;
          cnt_d      = cnt_q + CntW'(1);
        end
      end
      deq_pkg::ActPushBack: begin
        if (full) begin
          meta_o.status = deq_pkg::StFull;
        end else begin
          back_d     = ptr_inc(back_q);
          mem_en_o   = 1'b1;
          mem_we_o   = 1'b1;
          mem_addr_o = back_q;
          cnt_d      = cnt_q + CntW'(1);
        end
      end
      deq_pkg::ActPopFront: begin
        if (empty) begin
          meta_o.status = deq_pkg::StEmpty;
        end else begin
          front_d    = ptr_inc(front_q);
          mem_en_o   = 1'b1;
          mem_addr_o = front_q;
          meta_o.pop = 1'b1;
          cnt_d      = cnt_q - CntW'(1);
        end
      end
      deq_pkg::ActPopBack: begin
        if (empty) begin
          meta_o.status = deq_pkg::StEmpty;
        end else begin
          back_d     = ptr_dec(back_q);
          mem_en_o   = 1'b1;
          mem_addr_o = back_d;
          meta_o.pop = 1'b1;
          cnt_d      = cnt_q - CntW'(1);
        end
      end
      default: begin
        meta_o.status = deq_pkg::StOk;
      end
    endcase
    // store is touched only for an accepted item
    mem_en_o = mem_en_o & accept_i;
    mem_we_o = mem_we_o & accept_i;
    // Occupancy as seen after the action, cut to the field width
    cnt_wide        = (CntW + deq_pkg::OccW)'(cnt_d);
    meta_o.occ      = cnt_wide[deq_pkg::OccW-1:0];
    meta_o.is_empty = (cnt_d == '0);
  end

  // Pointer and count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= '0;
      cnt_q   <= '0;
    end else if (accept_i) begin
      front_q <= front_d;
      back_q  <= back_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== design/deq_out.sv =====
// Result path: read-data stage with hold register, then the output register.
module deq_out #(
  parameter int unsigned DATA_WIDTH = deq_pkg::DefDataWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  deq_pkg::deq_meta_t     meta_i,
  input  logic [DATA_WIDTH-1:0]  mem_rdata_i,
  output logic                   ready_o,
  deq_out_if.source              rsp
);

  logic                   s1_valid_q;
  logic                   s1_fresh_q;
  deq_pkg::deq_meta_t     s1_meta_q;
  logic [DATA_WIDTH-1:0]  s1_hold_q;
  logic                   s1_adv;
  logic [DATA_WIDTH-1:0]  s1_data;
  logic [63:0]            s1_data_wide;

  logic                          out_valid_q;
  logic [deq_pkg::ValueW-1:0]    out_value_q;
  deq_pkg::deq_meta_t            out_meta_q;

  // Stage 1 moves on when the output register is free or being emptied
  assign s1_adv  = !out_valid_q || rsp.ready;
  assign ready_o = !s1_valid_q || s1_adv;

  // Read data is live only in the cycle after the read, held after that
  assign s1_data      = s1_fresh_q ? mem_rdata_i : s1_hold_q;
  assign s1_data_wide = 64'(s1_data);

  // Stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_fresh_q <= 1'b0;
    end else begin
      if (accept_i) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      s1_fresh_q <= accept_i;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_meta_q <= meta_i;
    end
    if (s1_fresh_q) begin
      s1_hold_q <= mem_rdata_i;
    end
  end

  // Output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_meta_q  <= s1_meta_q;
      out_value_q <= s1_meta_q.pop ? s1_data_wide[deq_pkg::ValueW-1:0] : '0;
    end
  end

  assign rsp.valid        = out_valid_q;
  assign rsp.popped_value = out_value_q;
  assign rsp.occupancy    = out_meta_q.occ;
  assign rsp.is_empty     = out_meta_q.is_empty;
  assign rsp.status       = out_meta_q.status;

endmodule

// ===== design/double_ended_queue_core.sv =====
// Top level of the bounded double-ended queue.
//
//  Channel  | Dir | Handshake           | Item fields
//  ---------+-----+---------------------+-----------------------------------------------
//  req_i    | in  | req_i.valid/ready   | action, push_value
//  rsp_o    | out | rsp_o.valid/ready   | popped_value, occupancy, is_empty, status
//
// One action is accepted per cycle while input ready is high; its result passes the read stage
// behind the store's registered read port, then the output register, before it is shown.
// Reset clears the pointers and count; the store itself is not cleared and needs no sweep.
// A stalled output holds the result; one more item is taken into the read stage, then
// input ready drops until the output register frees.
module double_ended_queue_core #(
  parameter int unsigned DEPTH      = deq_pkg::DefDepth,
  parameter int unsigned DATA_WIDTH = deq_pkg::DefDataWidth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  deq_in_if.sink     req_i,
  deq_out_if.source  rsp_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);

  logic                  accept;
  logic                  ready;
  logic                  mem_en;
  logic                  mem_we;
  logic [PtrW-1:0]       mem_addr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [DATA_WIDTH-1:0] mem_rdata;
  deq_pkg::deq_meta_t    meta;

  assign req_i.ready = ready;
  assign accept      = req_i.valid && ready;

  deq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .action_i     (req_i.action),
    .push_value_i (req_i.push_value),
    .mem_en_o     (mem_en),
    .mem_we_o     (mem_we),
    .mem_addr_o   (mem_addr),
    .mem_wdata_o  (mem_wdata),
    .meta_o       (meta)
  );

  deq_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  deq_out #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .meta_i      (meta),
    .mem_rdata_i (mem_rdata),
    .ready_o     (ready),
    .rsp         (rsp_o)
  );

endmodule

// ===== tb/tb_top.sv =====
// Testbench of the double-ended queue: directed table, then random actions checked by a predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  localparam int unsigned QDepth    = DefDepth;
  localparam int unsigned PtrW      = $clog2(QDepth);
  localparam int unsigned DirRows   = 20;
  localparam int unsigned RandItems = 510;

  // One result item as the queue should show it
  typedef struct packed {
    logic [ValueW-1:0] popped;
    logic [OccW-1:0]   occ;
    logic              empty;
    deq_status_e       status;
  } deq_rsp_t;

  // One row of the directed table; rows repeated more than once take random words
  typedef struct packed {
    deq_action_e       act;
    logic [ValueW-1:0] val;
    logic [4:0]        reps;
    logic              typed;
    deq_rsp_t          rsp;
  } deq_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  deq_in_if  req_if ();
  deq_out_if rsp_if ();

  double_ended_queue_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the queue contents
  logic [ValueW-1:0] shadow_store [QDepth];
  logic [PtrW-1:0]   shadow_front = '0;
  logic [PtrW-1:0]   shadow_back  = '0;
  logic [OccW-1:0]   shadow_count = '0;

  deq_rsp_t    pending_results [$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned n_errors   = 0;
  int unsigned n_actions  = 0;
  int unsigned n_results  = 0;
  int unsigned n_full     = 0;
  int unsigned n_starved  = 0;

  // Directed walk: empty pops, extremes, last-element pops, fill to full, refused pushes
  deq_row_t dir_tab [DirRows] = '{
    '{ActPopFront,  32'h0000_0000, 5'd1,  1'b1, '{32'h0000_0000, 5'd0,  1'b1, StEmpty}},
    '{ActPopBack,   32'hffff_ffff, 5'd1,  1'b1, '{32'h0000_0000, 5'd0,  1'b1, StEmpty}},
    '{ActPushBack,  32'hffff_ffff, 5'd1,  1'b1, '{32'h0000_0000, 5'd1,  1'b0, StOk}},
    '{ActPushFront, 32'h0000_0000, 5'd1,  1'b1, '{32'h0000_0000, 5'd2,  1'b0, StOk}},
    '{ActPopBack,   32'h0000_0000, 5'd1,  1'b1, '{32'hffff_ffff, 5'd1,  1'b0, StOk}},
    '{ActPopBack,   32'h0000_0000, 5'd1,  1'b1, '{32'h0000_0000, 5'd0,  1'b1, StOk}},
    '{ActPushFront, 32'h8000_0001, 5'd1,  1'b1, '{32'h0000_0000, 5'd1,  1'b0, StOk}},
    '{ActPopFront,  32'h0000_0000, 5'd1,  1'b1, '{32'h8000_0001, 5'd0,  1'b1, StOk}},
    '{ActPopFront,  32'h0000_0000, 5'd1,  1'b1, '{32'h0000_0000, 5'd0,  1'b1, StEmpty}},
    '{ActPushFront, 32'h0000_0000, 5'd1,  1'b1, '{32'h0000_0000, 5'd1,  1'b0, StOk}},
    '{ActPushBack,  32'h0000_0000, 5'd14, 1'b0, '0},
    '{ActPushFront, 32'h5a5a_5a5a, 5'd1,  1'b1, '{32'h0000_0000, 5'd16, 1'b0, StOk}},
    '{ActPushBack,  32'h1234_5678, 5'd1,  1'b1, '{32'h0000_0000, 5'd16, 1'b0, StFull}},
    '{ActPushFront, 32'hffff_ffff, 5'd1,  1'b1, '{32'h0000_0000, 5'd16, 1'b0, StFull}},
    '{ActPopFront,  32'h0000_0000, 5'd1,  1'b1, '{32'h5a5a_5a5a, 5'd15, 1'b0, StOk}},
    '{ActPushBack,  32'hdead_beef, 5'd1,  1'b0, '0},
    '{ActPopBack,   32'h0000_0000, 5'd1,  1'b0, '0},
    '{ActPopBack,   32'h0000_0000, 5'd14, 1'b0, '0},
    '{ActPopFront,  32'h0000_0000, 5'd1,  1'b1, '{32'h0000_0000, 5'd0,  1'b1, StOk}},
    '{ActPopBack,   32'h0000_0000, 5'd1,  1'b1, '{32'h0000_0000, 5'd0,  1'b1, StEmpty}}
  };

  // Apply one action to the shadow queue and return the result it should give
  function automatic deq_rsp_t deq_apply(deq_action_e act, logic [ValueW-1:0] val);
    deq_rsp_t r;
    r = '{popped: '0, occ: '0, empty: 1'b0, status: StOk};
    case (act)
      ActPushFront, ActPushBack: begin
        if (shadow_count == QDepth) begin
          r.status = StFull;
        end else if (act == ActPushFront) begin
          shadow_front               = shadow_front - 1'b1;
          shadow_store[shadow_front] = val;
          shadow_count               = shadow_count + 1'b1;
        end else begin
          shadow_store[shadow_back] = val;
          shadow_back               = shadow_back + 1'b1;
          shadow_count              = shadow_count + 1'b1;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          r.status = StEmpty;
        end else if (act == ActPopFront) begin
          r.popped     = shadow_store[shadow_front];
          shadow_front = shadow_front + 1'b1;
          shadow_count = shadow_count - 1'b1;
        end else begin
          shadow_back  = shadow_back - 1'b1;
          r.popped     = shadow_store[shadow_back];
          shadow_count = shadow_count - 1'b1;
        end
      end
    endcase
    r.occ   = shadow_count;
    r.empty = (shadow_count == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // Offer one item from a falling edge, hold it until taken, note its expected result
  task automatic put_item(deq_action_e act, logic [ValueW-1:0] val, logic typed,
                          deq_rsp_t typed_rsp);
    deq_rsp_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.action     <= act;
    req_if.push_value <= val;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    pred = deq_apply(act, val);
    pending_results.push_back(typed ? typed_rsp : pred);
    n_actions++;
    if (pred.status == StFull) n_full++;
    if (pred.status == StEmpty) n_starved++;
    @(negedge clk_i);
  endtask

  // Stop sending until every outstanding result has come back
  task automatic hold_until_drained();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  // Bursts leaning towards pushes, towards pops or balanced, so the queue runs full and empty often
  task automatic run_random(int unsigned n_items);
    int unsigned push_bias;
    int unsigned burst_left;
    deq_action_e act;
    logic [ValueW-1:0] val;
    push_bias  = 50;
    burst_left = 0;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (burst_left == 0) begin
        case ($urandom_range(2))
          0:       push_bias = 15;
          1:       push_bias = 50;
          default: push_bias = 85;
        endcase
        burst_left = $urandom_range(40, 8);
      end
      burst_left--;
      if ($urandom_range(99) < push_bias) begin
        act = $urandom_range(1) ? ActPushBack : ActPushFront;
      end else begin
        act = $urandom_range(1) ? ActPopBack : ActPopFront;
      end
      case ($urandom_range(15))
        0:       val = '0;
        1:       val = '1;
        default: val = $urandom;
      endcase
      put_item(act, val, 1'b0, '0);
      if (i % 173 == 172) hold_until_drained();
    end
  endtask

  // Receiver back-pressure
  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker: every taken result against the oldest expectation
  always @(posedge clk_i) begin
    deq_rsp_t want;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", rsp_if.popped_value, '0);
      end else begin
        want = pending_results.pop_front();
        n_results++;
        if (rsp_if.popped_value !== want.popped)
          report_mismatch("popped_value", rsp_if.popped_value, want.popped);
        if (rsp_if.occupancy !== want.occ)
          report_mismatch("occupancy", rsp_if.occupancy, want.occ);
        if (rsp_if.is_empty !== want.empty)
          report_mismatch("is_empty", rsp_if.is_empty, want.empty);
        if (rsp_if.status !== want.status)
          report_mismatch("status", rsp_if.status, want.status);
      end
    end
  end

  // Main sequence
  initial begin
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.action     = ActPushFront;
    req_if.push_value = '0;
    rsp_if.ready      = 1'b0;
    send_idle_pct     = 16;
    recv_idle_pct     = 51;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[k]) begin
      for (int unsigned r = 0; r < dir_tab[k].reps; r++) begin
        put_item(dir_tab[k].act, (dir_tab[k].reps > 1) ? $urandom : dir_tab[k].val,
                 dir_tab[k].typed, dir_tab[k].rsp);
      end
    end
    hold_until_drained();

    // Sender idles lightly and receiver about half the time, then the reverse, then no idling at all
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 51;
        end
        1: begin
          send_idle_pct = 51;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      run_random(RandItems);
      hold_until_drained();
    end

    repeat (8) @(negedge clk_i);
    $display("Ran %0d actions at three idle mixes; %0d results checked.", n_actions, n_results);
    $display("Refused pushes on a full queue: %0d, refused pops on an empty one: %0d.",
             n_full, n_starved);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/deq_pkg.sv
design/deq_in_if.sv
design/deq_out_if.sv
design/deq_mem.sv
design/deq_ctrl.sv
design/deq_out.sv
design/double_ended_queue_core.sv
tb/tb_top.sv
